// ===== src/precip_flux_gauss_quadrature_top_macros.svh =====
// assertion macros for the checker file of the precipitated-flux block
`ifndef PRECIP_FLUX_GAUSS_QUADRATURE_TOP_MACROS_SVH
`define PRECIP_FLUX_GAUSS_QUADRATURE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFGQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PFGQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pfgq_pkg.sv =====
// types and constants of the precipitated-flux quadrature block
`default_nettype none

package pfgq_pkg;

  localparam int NODES         = 5;
  localparam int HORNER_STEPS  = 6;

  typedef logic [31:0]        u32_t;
  typedef logic signed [63:0] flux_t;
  typedef logic signed [35:0] ang_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOSS_CONE   = 2'd0,
    CFG_FOCUS_GAIN  = 2'd1,
    CFG_PITCH_SHAPE = 2'd2
  } cfg_reg_t;

  localparam logic [30:0] LOSS_CONE_RESET  = 31'd0;
  localparam logic [31:0] FOCUS_GAIN_RESET = 32'd65536;

  // output range ends
  localparam flux_t FLUX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam flux_t FLUX_MIN = 64'sh8000_0000_0000_0000;

  // angles in Q.30
  localparam ang_t PI_Q30    = 36'sd3373259426;
  localparam ang_t HPI_Q30   = 36'sd1686629713;
  localparam ang_t TWOPI_Q30 = 36'sd6746518852;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // node offsets (1 - t)/2 in Q0.32
  localparam logic [31:0] NODE_C [NODES] = '{
    32'd2147483648, 32'd991129613, 32'd3303837683, 32'd201477238, 32'd4093490058
  };

  // per-node weights in Q.30 for the two pitch shapes
  localparam logic [29:0] RAMP_W [NODES] = '{
    30'd418335624, 30'd682758904, 30'd108713783, 30'd471814387, 30'd4885311
  };
  localparam logic [29:0] SQUARE_W [NODES] = '{
    30'd639669945, 30'd687594930, 30'd356228152, 30'd387669707, 30'd78230274
  };

  // taylor divisors and floor(2^32 / divisor)
  localparam logic [7:0] HORNER_DIV [HORNER_STEPS] = '{
    8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
    32'd27531841, 32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364,
    32'd715827882
  };

endpackage

`default_nettype wire

// ===== src/pfgq_in_if.sv =====
// input channel: one grid cell per transfer
`default_nettype none

interface pfgq_in_if;
  import pfgq_pkg::*;

  logic valid;
  logic ready;
  u32_t mean_sq_deflection;
  u32_t flux_magnitude;

  modport source (output valid, mean_sq_deflection, flux_magnitude, input ready);
  modport sink   (input valid, mean_sq_deflection, flux_magnitude, output ready);
endinterface

`default_nettype wire

// ===== src/pfgq_out_if.sv =====
// result channel: precipitated flux and clamp flag per transfer
`default_nettype none

interface pfgq_out_if;
  import pfgq_pkg::*;

  logic  valid;
  logic  ready;
  flux_t precip_flux;
  logic  saturated;

  modport source (output valid, precip_flux, saturated, input ready);
  modport sink   (input valid, precip_flux, saturated, output ready);
endinterface

`default_nettype wire

// ===== src/precip_flux_gauss_quadrature_top.sv =====
// precipitated-flux gauss quadrature, fully pipelined
//
// Usage:
//   in_ch  : mean-square deflection (Q2.30) and flux magnitude b (Q24.8) per cell
//   out_ch : precip_flux (signed Q40.24) and saturated, one result per cell
//   cfg_*  : write-only registers (loss cone, focus gain, pitch shape), written
//            with cfg_we high; write them only while the pipeline is empty
// Pipeline:
//   input register and 32 bit-per-stage square root stages, then 30 stages of
//   node angles, sine series (three stages per taylor term), weighted sum and
//   output scaling; throughput one cell per cycle unless the output stalls,
//   with all five nodes worked in parallel lanes
// Reset:
//   rst_n synchronous active low; clears the valid bits and loads the register
//   defaults (loss cone 0, focus gain 1.0, sine-ramp shape)
// Stall:
//   when a result waits and out_ch.ready is low, the whole pipeline holds and
//   in_ch.ready drops; nothing is lost or repeated
`default_nettype none

module precip_flux_gauss_quadrature_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  pfgq_in_if.sink                   in_ch,
  pfgq_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire pfgq_pkg::u32_t       cfg_data
);
  import pfgq_pkg::*;

  localparam int SQ_STEPS    = 32;
  localparam int POST_STAGES = 30;
  localparam int LAT         = SQ_STEPS + 1 + POST_STAGES;
  localparam int SIDE_LAST   = 28;

  typedef struct packed {
    logic [31:0] y2;
    logic [30:0] y;
    logic        yneg;
  } lane_t;

  typedef struct packed {
    logic [31:0] b;
    logic [32:0] pk;
  } side_t;

  // configuration registers
  logic [30:0] lc_r;
  logic [31:0] fg_r;
  logic        shape_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r    <= LOSS_CONE_RESET;
      fg_r    <= FOCUS_GAIN_RESET;
      shape_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOSS_CONE:   lc_r    <= cfg_data[30:0];
        CFG_FOCUS_GAIN:  fg_r    <= cfg_data;
        CFG_PITCH_SHAPE: shape_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves unless a finished result is held
  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // square root of v * 2^31, one result bit per stage
  logic [63:0] sq_n_r    [0:SQ_STEPS-1];
  logic [63:0] sq_root_r [0:SQ_STEPS];
  logic [31:0] sq_b_r    [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n_r[0]    <= {1'b0, in_ch.mean_sq_deflection, 31'b0};
      sq_root_r[0] <= '0;
      sq_b_r[0]    <= in_ch.flux_magnitude;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic [63:0] n_nxt;
    logic [63:0] root_nxt;

    always_comb begin
      trial = sq_root_r[k] + SQ_BIT;
      if (sq_n_r[k] >= trial) begin
        n_nxt    = sq_n_r[k] - trial;
        root_nxt = (sq_root_r[k] >> 1) + SQ_BIT;
      end else begin
        n_nxt    = sq_n_r[k];
        root_nxt = sq_root_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_root_r[k+1] <= root_nxt;
        sq_b_r[k+1]    <= sq_b_r[k];
      end
    end

    if (k < SQ_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_n_r[k+1] <= n_nxt;
        end
      end
    end
  end

  // node offsets round(c_i * da) and the shape factor
  logic [31:0] da;
  logic [31:0] off_nxt [NODES];
  logic [31:0] off_r   [NODES];
  side_t       side_nxt;
  side_t       side_r  [1:SIDE_LAST];

  assign da = sq_root_r[SQ_STEPS][31:0];

  always_comb begin
    logic [63:0] prod;
    logic [63:0] dsq;
    for (int i = 0; i < NODES; i++) begin
      prod       = 64'(NODE_C[i]) * 64'(da) + 64'h8000_0000;
      off_nxt[i] = prod[63:32];
    end
    dsq        = 64'(da) * 64'(da) + 64'h4000_0000;
    side_nxt.b = sq_b_r[SQ_STEPS];
    side_nxt.pk = shape_r ? {1'b0, da} : dsq[63:31];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      off_r     <= off_nxt;
      side_r[1] <= side_nxt;
      for (int s = 2; s <= SIDE_LAST; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // node angle 2*x folded into [-pi/2, pi/2]
  logic [30:0] by_nxt    [NODES];
  logic        byneg_nxt [NODES];
  logic [30:0] by_r      [NODES];
  logic        byneg_r   [NODES];

  always_comb begin
    ang_t x;
    ang_t th;
    for (int i = 0; i < NODES; i++) begin
      x  = ang_t'({5'b0, lc_r}) - ang_t'({4'b0, off_r[i]});
      th = x + x;
      if (th > PI_Q30) th = th - TWOPI_Q30;
      if (th < -PI_Q30) th = th + TWOPI_Q30;
      if (th > HPI_Q30) th = PI_Q30 - th;
      else if (th < -HPI_Q30) th = -PI_Q30 - th;
      byneg_nxt[i] = th[35];
      by_nxt[i]    = th[35] ? 31'(-th) : 31'(th);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      by_r    <= by_nxt;
      byneg_r <= byneg_nxt;
    end
  end

  // squared angle, start of the taylor series
  lane_t       hc_lane_r [0:HORNER_STEPS][NODES];
  logic [30:0] hc_poly_r [0:HORNER_STEPS][NODES];
  lane_t       hc0_nxt   [NODES];

  always_comb begin
    logic [61:0] sq;
    for (int i = 0; i < NODES; i++) begin
      sq              = 62'(by_r[i]) * 62'(by_r[i]) + 62'h2000_0000;
      hc0_nxt[i].y2   = sq[61:30];
      hc0_nxt[i].y    = by_r[i];
      hc0_nxt[i].yneg = byneg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hc_lane_r[0] <= hc0_nxt;
      for (int i = 0; i < NODES; i++) begin
        hc_poly_r[0][i] <= ONE_Q30;
      end
    end
  end

  // horner steps r = 1 - round(y2 * r) / d, three stages each
  lane_t       ha_lane_r [HORNER_STEPS][NODES];
  logic [62:0] ha_prod_r [HORNER_STEPS][NODES];
  lane_t       hb_lane_r [HORNER_STEPS][NODES];
  logic [31:0] hb_p_r    [HORNER_STEPS][NODES];
  logic [31:0] hb_q_r    [HORNER_STEPS][NODES];

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    logic [62:0] prod_nxt [NODES];
    logic [31:0] p_nxt    [NODES];
    logic [31:0] q_nxt    [NODES];
    logic [30:0] r_nxt    [NODES];

    // multiply by the running polynomial
    always_comb begin
      for (int i = 0; i < NODES; i++) begin
        prod_nxt[i] = 63'(hc_lane_r[k][i].y2) * 63'(hc_poly_r[k][i]);
      end
    end

    // round and multiply by the divisor reciprocal
    always_comb begin
      logic [62:0] ps;
      logic [63:0] pm;
      for (int i = 0; i < NODES; i++) begin
        ps       = ha_prod_r[k][i] + 63'h2000_0000;
        p_nxt[i] = ps[61:30];
        pm       = 64'(p_nxt[i]) * 64'(HORNER_RECIP[k]);
        q_nxt[i] = pm[63:32];
      end
    end

    // quotient correction and subtract from one
    always_comb begin
      logic [31:0] rem;
      logic [31:0] q;
      for (int i = 0; i < NODES; i++) begin
        rem = hb_p_r[k][i] - 32'(hb_q_r[k][i] * 32'(HORNER_DIV[k]));
        q   = (rem >= 32'(HORNER_DIV[k])) ? hb_q_r[k][i] + 32'd1 : hb_q_r[k][i];
        r_nxt[i] = ONE_Q30 - q[30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ha_prod_r[k]   <= prod_nxt;
        ha_lane_r[k]   <= hc_lane_r[k];
        hb_p_r[k]      <= p_nxt;
        hb_q_r[k]      <= q_nxt;
        hb_lane_r[k]   <= ha_lane_r[k];
        hc_poly_r[k+1] <= r_nxt;
        hc_lane_r[k+1] <= hb_lane_r[k];
      end
    end
  end

  // sine = round(y * r) with the sign restored
  logic signed [31:0] es_nxt [NODES];
  logic signed [31:0] es_r   [NODES];

  always_comb begin
    logic [61:0] sp;
    for (int i = 0; i < NODES; i++) begin
      sp = 62'(hc_lane_r[HORNER_STEPS][i].y) * 62'(hc_poly_r[HORNER_STEPS][i])
           + 62'h2000_0000;
      es_nxt[i] = hc_lane_r[HORNER_STEPS][i].yneg ? 32'sd0 - $signed(sp[61:30])
                                                  : $signed(sp[61:30]);
    end
  end

  // weight times sine, Q.60
  logic signed [63:0] wp_nxt [NODES];
  logic signed [63:0] wp_r   [NODES];

  always_comb begin
    logic [29:0] w;
    for (int i = 0; i < NODES; i++) begin
      w         = shape_r ? SQUARE_W[i] : RAMP_W[i];
      wp_nxt[i] = $signed({2'b00, w}) * es_r[i];
    end
  end

  // two-level sum of the node terms
  logic signed [63:0] g1_r [3];
  logic signed [63:0] acc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      es_r    <= es_nxt;
      wp_r    <= wp_nxt;
      g1_r[0] <= wp_r[0] + wp_r[1];
      g1_r[1] <= wp_r[2] + wp_r[3];
      g1_r[2] <= wp_r[4];
      acc_r   <= g1_r[0] + g1_r[1] + g1_r[2];
    end
  end

  // magnitude rounded to Q.30, sign kept aside
  logic [33:0] h_m_nxt;
  logic [33:0] h_m_r;
  logic        h_neg_r;

  always_comb begin
    logic [63:0] mag;
    mag     = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
    mag     = mag + 64'h2000_0000;
    h_m_nxt = mag[63:30];
  end

  // scale by the shape factor, then by the focus gain
  logic [32:0] i_t30_nxt;
  logic [32:0] i_t30_r;
  logic        i_neg_r;
  logic [41:0] j_u24_nxt;
  logic [41:0] j_u24_r;
  logic        j_neg_r;

  always_comb begin
    logic [66:0] mp;
    logic [63:0] ts;
    mp        = 67'(h_m_r) * 67'(side_r[SIDE_LAST-2].pk);
    ts        = mp[63:0] + 64'h4000_0000;
    i_t30_nxt = ts[63:31];
  end

  always_comb begin
    logic [64:0] gp;
    logic [63:0] us;
    gp        = 65'(i_t30_r) * 65'(fg_r);
    us        = gp[63:0] + 64'h20_0000;
    j_u24_nxt = us[63:22];
  end

  // times b, split in high and low halves
  logic [41:0] k_hi_full;
  logic [55:0] k_lo_nxt;
  logic        k_hisat_r;
  logic [38:0] k_hi_r;
  logic [55:0] k_lo_r;
  logic        k_neg_r;

  always_comb begin
    logic [63:0] ls;
    k_hi_full = 42'(j_u24_r[41:32]) * 42'(side_r[SIDE_LAST].b);
    ls        = 64'(j_u24_r[31:0]) * 64'(side_r[SIDE_LAST].b) + 64'd128;
    k_lo_nxt  = ls[63:8];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_m_r     <= h_m_nxt;
      h_neg_r   <= acc_r[63];
      i_t30_r   <= i_t30_nxt;
      i_neg_r   <= h_neg_r;
      j_u24_r   <= j_u24_nxt;
      j_neg_r   <= i_neg_r;
      k_hisat_r <= |k_hi_full[41:39];
      k_hi_r    <= k_hi_full[38:0];
      k_lo_r    <= k_lo_nxt;
      k_neg_r   <= j_neg_r;
    end
  end

  // combine, clamp and apply sign
  flux_t out_flux_nxt;
  flux_t out_flux_r;
  logic  out_sat_nxt;
  logic  out_sat_r;

  always_comb begin
    logic [63:0] q;
    logic [63:0] lim;
    q           = {1'b0, k_hi_r, 24'b0} + {8'b0, k_lo_r};
    lim         = k_neg_r ? 64'(FLUX_MIN) : 64'(FLUX_MAX);
    out_sat_nxt = k_hisat_r || (q > lim);
    if (out_sat_nxt) q = lim;
    out_flux_nxt = k_neg_r ? flux_t'(64'd0 - q) : flux_t'(q);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_flux_r <= out_flux_nxt;
      out_sat_r  <= out_sat_nxt;
    end
  end

  assign out_ch.precip_flux = out_flux_r;
  assign out_ch.saturated   = out_sat_r;

endmodule

`default_nettype wire

// ===== src/pfgq_checker.sv =====
// port-level checks of the precipitated-flux block, bound to the top level
`default_nettype none
`include "precip_flux_gauss_quadrature_top_macros.svh"

module pfgq_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire pfgq_pkg::flux_t out_precip_flux,
  input wire logic           out_saturated
);
  import pfgq_pkg::*;

  // a waiting result stays offered
  `PFGQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn while stalled")

  // the pipeline takes input whenever the output side is free
  `PFGQ_ASSERT_IMP(a_ready_empty, !out_valid, in_ready, "input blocked with empty output")
  `PFGQ_ASSERT_IMP(a_ready_drain, out_valid && out_ready, in_ready, "input blocked while draining")

  // a clamped result sits on one end of the range
  `PFGQ_ASSERT_IMP(a_sat_clamp, out_valid && out_saturated, (out_precip_flux == FLUX_MAX) || (out_precip_flux == FLUX_MIN), "saturated result not at range end")

endmodule

bind precip_flux_gauss_quadrature_top pfgq_checker u_pfgq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_precip_flux (out_ch.precip_flux),
  .out_saturated   (out_ch.saturated)
);

`default_nettype wire
